// ===== rtl/assert_macros.svh =====
// assertion helpers for the unranking block checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define KCU_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define KCU_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/kcu_pkg.sv =====
package kcu_pkg;

   localparam int KCU_MAX_LEN = 64;

   localparam int LEN_W    = 7;
   localparam int RANK_W   = 30;
   localparam int BITS_W   = 64;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 30;
   // enough for a (64+1) x (64+1) triangle
   localparam int ADDR_W   = 13;

   localparam logic [CNT_W-1:0] BINO_LIMIT = 30'd1000000100;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANK   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LENGTH = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RUN,
      ST_RESULT
   } kcu_state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
   } kcu_rd_req_type;

   typedef struct packed {
      logic [CNT_W-1:0] data_a;
      logic [CNT_W-1:0] data_b;
      logic             ready;
   } kcu_rd_rsp_type;

   typedef struct packed {
      logic                valid;
      logic [BITS_W-1:0]   bits;
      logic [LEN_W-1:0]    length;
      logic [STATUS_W-1:0] status;
   } kcu_result_type;

endpackage

// ===== rtl/kcu_binom_mem.sv =====
module kcu_binom_mem
   import kcu_pkg::*;
#(
   parameter int MAX_LEN = KCU_MAX_LEN
) (
   input  logic           clock,
   input  logic           reset,
   input  kcu_rd_req_type rd_req,
   output kcu_rd_rsp_type rd_rsp
);

   localparam int Dim   = MAX_LEN + 1;
   localparam int Depth = Dim * Dim;
   localparam logic [LEN_W-1:0] LastIdx = LEN_W'(MAX_LEN);

   logic [CNT_W-1:0] mem_array [Depth];

   // fill sweep: stage a issues the read of the row above, stage b writes
   logic               fill_act_ff, fill_act_in;
   logic [LEN_W-1:0]   fill_row_ff, fill_row_in;
   logic [LEN_W-1:0]   fill_col_ff, fill_col_in;
   logic               wr_act_ff, wr_act_in;
   logic [LEN_W-1:0]   wr_row_ff, wr_row_in;
   logic [LEN_W-1:0]   wr_col_ff, wr_col_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   rdata_a_ff;
   logic [CNT_W-1:0]   rdata_b_ff;

   logic [LEN_W-1:0]   up_row;
   logic [ADDR_W-1:0]  fill_addr;
   logic [ADDR_W-1:0]  port_a_addr;
   logic               port_a_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [CNT_W-1:0]   wr_data;
   logic [CNT_W:0]     pair_sum;
   logic [CNT_W-1:0]   left_term;

   always_comb begin
      up_row      = (fill_row_ff == '0) ? '0 : fill_row_ff - 1'b1;
      fill_addr   = ADDR_W'(up_row) * ADDR_W'(Dim) + ADDR_W'(fill_col_ff);
      port_a_en   = fill_act_ff || rd_req.en;
      port_a_addr = fill_act_ff ? fill_addr : rd_req.addr_a;
      wr_addr     = ADDR_W'(wr_row_ff) * ADDR_W'(Dim) + ADDR_W'(wr_col_ff);
   end

   // pascal rule, saturated
   always_comb begin
      left_term = (wr_col_ff == '0) ? '0 : left_ff;
      pair_sum  = {1'b0, left_term} + {1'b0, rdata_a_ff};
      if (wr_row_ff == '0) begin
         wr_data = (wr_col_ff == '0) ? CNT_W'(1) : '0;
      end else if (pair_sum > {1'b0, BINO_LIMIT}) begin
         wr_data = BINO_LIMIT;
      end else begin
         wr_data = pair_sum[CNT_W-1:0];
      end
   end

   always_comb begin
      fill_act_in = fill_act_ff;
      fill_row_in = fill_row_ff;
      fill_col_in = fill_col_ff;
      if (fill_act_ff) begin
         if (fill_col_ff == LastIdx) begin
            fill_col_in = '0;
            fill_row_in = fill_row_ff + 1'b1;
            if (fill_row_ff == LastIdx) begin
               fill_act_in = 1'b0;
            end
         end else begin
            fill_col_in = fill_col_ff + 1'b1;
         end
      end
      wr_act_in = fill_act_ff;
      wr_row_in = fill_row_ff;
      wr_col_in = fill_col_ff;
      left_in   = wr_act_ff ? rdata_a_ff : left_ff;
      done_in   = done_ff || (wr_act_ff && wr_row_ff == LastIdx && wr_col_ff == LastIdx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_act_ff <= 1'b1;
         fill_row_ff <= '0;
         fill_col_ff <= '0;
         wr_act_ff   <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         fill_act_ff <= fill_act_in;
         fill_row_ff <= fill_row_in;
         fill_col_ff <= fill_col_in;
         wr_act_ff   <= wr_act_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_row_ff <= wr_row_in;
      wr_col_ff <= wr_col_in;
      left_ff   <= left_in;
   end

   always_ff @(posedge clock) begin
      if (wr_act_ff) begin
         mem_array[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (port_a_en) begin
         rdata_a_ff <= mem_array[port_a_addr];
      end
      if (rd_req.en) begin
         rdata_b_ff <= mem_array[rd_req.addr_b];
      end
   end

   assign rd_rsp.data_a = rdata_a_ff;
   assign rd_rsp.data_b = rdata_b_ff;
   assign rd_rsp.ready  = done_ff;

endmodule

// ===== rtl/kcu_unrank_core.sv =====
module kcu_unrank_core
   import kcu_pkg::*;
#(
   parameter int MAX_LEN = KCU_MAX_LEN
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [LEN_W-1:0]  req_dash_count,
   input  logic [LEN_W-1:0]  req_dot_count,
   input  logic [RANK_W-1:0] req_rank,
   output kcu_rd_req_type    rd_req,
   input  kcu_rd_rsp_type    rd_rsp,
   output kcu_result_type    result,
   input  logic              take
);

   localparam int Dim   = MAX_LEN + 1;
   localparam int PosW  = $clog2(BITS_W);

   kcu_state_type          state_ff, state_in;
   logic [LEN_W-1:0]       dash_ff, dash_in;
   logic [LEN_W-1:0]       dot_ff, dot_in;
   logic [RANK_W-1:0]      rank_ff, rank_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [PosW-1:0]        pos_ff, pos_in;
   logic                   sel_ff, sel_in;
   logic [BITS_W-1:0]      bits_ff, bits_in;
   logic [STATUS_W-1:0]    status_ff, status_in;

   logic                   accept;
   logic [LEN_W:0]         len_sum;
   logic                   too_long;
   logic [LEN_W-1:0]       remain;
   logic [CNT_W-1:0]       count;
   logic                   pick_dash;
   logic                   rank_over;

   function automatic logic [ADDR_W-1:0] tab_addr(input logic [LEN_W-1:0] row,
                                                  input logic [LEN_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(Dim) + ADDR_W'(col);
   endfunction

   always_comb begin
      accept    = req_valid && req_ready;
      len_sum   = {1'b0, req_dash_count} + {1'b0, req_dot_count};
      too_long  = len_sum > (LEN_W+1)'(MAX_LEN);
      remain    = dash_ff + dot_ff;
      count     = (dash_ff == '0) ? '0 : (sel_ff ? rd_rsp.data_b : rd_rsp.data_a);
      pick_dash = (dash_ff != '0) && ((dot_ff == '0) || (rank_ff < count));
      rank_over = rank_ff >= rd_rsp.data_a;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = too_long ? ST_RESULT : ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = (rank_over || len_ff == '0) ? ST_RESULT : ST_RUN;
         end
         ST_RUN: begin
            if (remain == LEN_W'(1)) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      rd_req.en     = 1'b0;
      rd_req.addr_a = '0;
      rd_req.addr_b = '0;
      result.valid  = 1'b0;
      result.bits   = bits_ff;
      result.length = len_ff;
      result.status = status_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = rd_rsp.ready;
            if (accept && !too_long) begin
               // total count, and the dash-first count for position zero
               rd_req.en     = 1'b1;
               rd_req.addr_a = tab_addr(len_sum[LEN_W-1:0], req_dash_count);
               if (len_sum != '0 && req_dash_count != '0) begin
                  rd_req.addr_b = tab_addr(len_sum[LEN_W-1:0] - 1'b1,
                                           req_dash_count - 1'b1);
               end
            end
         end
         ST_RUN: begin
            // prefetch next count for both outcomes of this position
            rd_req.en = 1'b1;
            if (remain >= LEN_W'(2) && dash_ff >= LEN_W'(2)) begin
               rd_req.addr_a = tab_addr(remain - LEN_W'(2), dash_ff - LEN_W'(2));
            end
            if (remain >= LEN_W'(2) && dash_ff != '0) begin
               rd_req.addr_b = tab_addr(remain - LEN_W'(2), dash_ff - 1'b1);
            end
         end
         ST_RESULT: begin
            result.valid = 1'b1;
         end
         ST_CHECK: begin
            rd_req.en = 1'b0;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      dash_in   = dash_ff;
      dot_in    = dot_ff;
      rank_in   = rank_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      sel_in    = sel_ff;
      bits_in   = bits_ff;
      status_in = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dash_in   = req_dash_count;
               dot_in    = req_dot_count;
               rank_in   = req_rank;
               bits_in   = '0;
               pos_in    = '0;
               sel_in    = 1'b1;
               len_in    = too_long ? '0 : len_sum[LEN_W-1:0];
               status_in = too_long ? STATUS_LENGTH : STATUS_OK;
            end
         end
         ST_CHECK: begin
            if (rank_over) begin
               status_in = STATUS_RANK;
            end
         end
         ST_RUN: begin
            bits_in = bits_ff | (BITS_W'(pick_dash) << pos_ff);
            pos_in  = pos_ff + 1'b1;
            sel_in  = !pick_dash;
            if (pick_dash) begin
               dash_in = dash_ff - 1'b1;
            end else begin
               dot_in  = dot_ff - 1'b1;
               rank_in = rank_ff - count;
            end
         end
         ST_RESULT: begin
            sel_in = sel_ff;
         end
         default: begin
            sel_in = sel_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      dash_ff   <= dash_in;
      dot_ff    <= dot_in;
      rank_ff   <= rank_in;
      len_ff    <= len_in;
      pos_ff    <= pos_in;
      sel_ff    <= sel_in;
      bits_ff   <= bits_in;
      status_ff <= status_in;
   end

endmodule

// ===== rtl/kth_combination_unrank.sv =====
// channel  | direction | ports                                              | handshake
// req      | in        | req_dash_count, req_dot_count, req_rank            | req_valid/req_ready
// rsp      | out       | rsp_signal_bits, rsp_signal_length, rsp_status     | rsp_valid/rsp_ready
//
// synchronous active-high reset starts a fill sweep of the whole binomial memory;
// req_ready stays low until it is done
// an item of len = dash_count + dot_count symbols takes one memory read plus one
// total-count check, then one placed symbol per cycle
// a rank at or beyond the total ends after the check, a length beyond MAX_LEN skips both
// the result sits in an output register, so the next item is taken while it stalls
module kth_combination_unrank
   import kcu_pkg::*;
#(
   parameter int MAX_LEN = KCU_MAX_LEN
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [LEN_W-1:0]    req_dash_count,
   input  logic [LEN_W-1:0]    req_dot_count,
   input  logic [RANK_W-1:0]   req_rank,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BITS_W-1:0]   rsp_signal_bits,
   output logic [LEN_W-1:0]    rsp_signal_length,
   output logic [STATUS_W-1:0] rsp_status
);

   kcu_rd_req_type rd_req;
   kcu_rd_rsp_type rd_rsp;
   kcu_result_type result;
   logic           take;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BITS_W-1:0]   rsp_bits_ff, rsp_bits_in;
   logic [LEN_W-1:0]    rsp_length_ff, rsp_length_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // binomial counts, pascal triangle saturated at the limit
   kcu_binom_mem #(
      .MAX_LEN(MAX_LEN)
   ) u_mem (
      .clock (clock),
      .reset (reset),
      .rd_req(rd_req),
      .rd_rsp(rd_rsp)
   );

   // sequencer and rank arithmetic, one position per cycle
   kcu_unrank_core #(
      .MAX_LEN(MAX_LEN)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_dash_count(req_dash_count),
      .req_dot_count (req_dot_count),
      .req_rank      (req_rank),
      .rd_req        (rd_req),
      .rd_rsp        (rd_rsp),
      .result        (result),
      .take          (take)
   );

   // hand over when the output register is empty or being drained
   always_comb begin
      take          = result.valid && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_bits_in   = rsp_bits_ff;
      rsp_length_in = rsp_length_ff;
      rsp_status_in = rsp_status_ff;
      if (take) begin
         rsp_valid_in  = 1'b1;
         rsp_bits_in   = result.bits;
         rsp_length_in = result.length;
         rsp_status_in = result.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_bits_ff   <= rsp_bits_in;
      rsp_length_ff <= rsp_length_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_signal_bits   = rsp_bits_ff;
   assign rsp_signal_length = rsp_length_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// ===== rtl/kcu_checker.sv =====
`include "assert_macros.svh"

module kcu_checker
   import kcu_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [BITS_W-1:0]   rsp_signal_bits,
   input logic [LEN_W-1:0]    rsp_signal_length,
   input logic [STATUS_W-1:0] rsp_status
);

   logic                              req_seen;
   logic                              rsp_stall;
   logic [BITS_W+LEN_W+STATUS_W-1:0]  rsp_payload;
   logic                              len_err;
   logic                              len_empty;
   logic                              rank_err;
   logic                              ok_item;
   logic [BITS_W-1:0]                 tail_bits;

   assign req_seen    = req_valid && req_ready;
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_signal_bits, rsp_signal_length, rsp_status};
   assign len_err     = rsp_valid && rsp_status == STATUS_LENGTH;
   assign len_empty   = rsp_signal_length == '0 && rsp_signal_bits == '0;
   assign rank_err    = rsp_valid && rsp_status == STATUS_RANK;
   assign ok_item     = rsp_valid && rsp_status == STATUS_OK;
   // symbols at and above the length
   assign tail_bits   = rsp_signal_bits >> rsp_signal_length;

   `KCU_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "stall changed item")
   `KCU_ASSERT_IMP(a_len_err, len_err, len_empty, "length error item not empty")
   `KCU_ASSERT_IMP(a_rank_err, rank_err, rsp_signal_bits == '0, "rank error item has symbols")
   `KCU_ASSERT_IMP(a_ok_tail, ok_item, tail_bits == '0, "symbols beyond length")
   `KCU_ASSERT_NXT(a_one_busy, req_seen, !req_ready, "item taken while busy")

endmodule

bind kth_combination_unrank kcu_checker u_kcu_checker (.*);

// ===== test/kth_combination_unrank_test.sv =====
class arrangement_checker;

   typedef struct packed {
      logic [kcu_pkg::BITS_W-1:0]   bits;
      logic [kcu_pkg::LEN_W-1:0]    length;
      logic [kcu_pkg::STATUS_W-1:0] status;
   } arrangement_type;

   int unsigned     pascal [0:64][0:64];
   arrangement_type expected_arrangements [$];
   int unsigned     mismatches;
   int unsigned     status_seen [0:3];

   function new();
      int unsigned sum;
      mismatches = 0;
      foreach (status_seen[s]) status_seen[s] = 0;
      for (int i = 0; i <= 64; i++) begin
         for (int j = 0; j <= 64; j++) begin
            if (j > i) begin
               pascal[i][j] = 0;
            end else if (j == 0 || j == i) begin
               pascal[i][j] = 1;
            end else begin
               sum = pascal[i-1][j-1] + pascal[i-1][j];
               pascal[i][j] = (sum > kcu_pkg::BINO_LIMIT) ? kcu_pkg::BINO_LIMIT : sum;
            end
         end
      end
   endfunction

   function arrangement_type predict_arrangement(logic [kcu_pkg::LEN_W-1:0] dash_in,
                                                 logic [kcu_pkg::LEN_W-1:0] dot_in,
                                                 logic [kcu_pkg::RANK_W-1:0] rank_in);
      arrangement_type result;
      int unsigned     dashes;
      int unsigned     dots;
      int unsigned     k;
      int unsigned     count;
      int unsigned     len;
      dashes = dash_in;
      dots   = dot_in;
      k      = rank_in;
      len    = dashes + dots;
      result = '0;
      if (len > kcu_pkg::KCU_MAX_LEN) begin
         result.status = kcu_pkg::STATUS_LENGTH;
         return result;
      end
      result.length = kcu_pkg::LEN_W'(len);
      if (k >= pascal[len][dashes]) begin
         result.status = kcu_pkg::STATUS_RANK;
         return result;
      end
      for (int pos = 0; pos < len; pos++) begin
         count = 0;
         if (dashes > 0) count = pascal[dashes + dots - 1][dashes - 1];
         if (dashes > 0 && (dots == 0 || k < count)) begin
            result.bits[pos] = 1'b1;
            dashes--;
         end else begin
            if (k >= count) k -= count;
            if (dots > 0) dots--;
         end
      end
      result.status = kcu_pkg::STATUS_OK;
      return result;
   endfunction

   function void note_request(logic [kcu_pkg::LEN_W-1:0] dash_in,
                              logic [kcu_pkg::LEN_W-1:0] dot_in,
                              logic [kcu_pkg::RANK_W-1:0] rank_in);
      expected_arrangements.push_back(predict_arrangement(dash_in, dot_in, rank_in));
   endfunction

   function void check_response(logic [kcu_pkg::BITS_W-1:0]   bits,
                                logic [kcu_pkg::LEN_W-1:0]    length,
                                logic [kcu_pkg::STATUS_W-1:0] status);
      arrangement_type want;
      if (expected_arrangements.size() == 0) begin
         $error("response item with none pending: bits %h length %0d status %0d",
                bits, length, status);
         mismatches++;
         return;
      end
      want = expected_arrangements.pop_front();
      status_seen[want.status]++;
      if (bits !== want.bits) begin
         $error("signal_bits: expected %h, actual %h", want.bits, bits);
         mismatches++;
      end
      if (length !== want.length) begin
         $error("signal_length: expected %0d, actual %0d", want.length, length);
         mismatches++;
      end
      if (status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, status);
         mismatches++;
      end
   endfunction

endclass

module kth_combination_unrank_test;
   import kcu_pkg::*;

   localparam int CLOCK_HALF      = 10;
   localparam int RESET_CYCLES    = 8;
   localparam int ITEMS_PER_PHASE = 300;
   localparam int RANK_MAX        = 1000000000;
   // drain margin for the last item through the block and the output register
   localparam int DRAIN_CYCLES    = 200;
   // fill sweep plus 923 items at worst-case item time and stalls, many times over
   localparam int CYCLE_LIMIT     = 600000;

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_ready;
   logic [LEN_W-1:0]    req_dash_count    = '0;
   logic [LEN_W-1:0]    req_dot_count     = '0;
   logic [RANK_W-1:0]   req_rank          = '0;
   logic                rsp_valid;
   logic                rsp_ready         = 1'b0;
   logic [BITS_W-1:0]   rsp_signal_bits;
   logic [LEN_W-1:0]    rsp_signal_length;
   logic [STATUS_W-1:0] rsp_status;

   // idle percentages for the current phase
   int unsigned sender_idle_pct   = 36;
   int unsigned receiver_idle_pct = 84;
   int unsigned cycle_count       = 0;
   int unsigned items_sent        = 0;

   arrangement_checker sb;

   kth_combination_unrank u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_dash_count    (req_dash_count),
      .req_dot_count     (req_dot_count),
      .req_rank          (req_rank),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_signal_bits   (rsp_signal_bits),
      .rsp_signal_length (rsp_signal_length),
      .rsp_status        (rsp_status)
   );

   // free-running clock, period 20
   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // receiver backpressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
   end

   // a response item is taken when valid and ready were both high before this edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_signal_bits, rsp_signal_length, rsp_status);
      end
   end

   // hard stop if the block hangs
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d responses still pending",
               cycle_count, sb.expected_arrangements.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // offer one request item and hold it until accepted
   task automatic send_item(input logic [LEN_W-1:0]  dash,
                            input logic [LEN_W-1:0]  dot,
                            input logic [RANK_W-1:0] rank);
      // valid only drops when an idle gap is actually taken
      if ($urandom_range(99, 0) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99, 0) < sender_idle_pct) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_dash_count <= dash;
      req_dot_count  <= dot;
      req_rank       <= rank;
      do @(posedge clock); while (!req_ready);
      sb.note_request(dash, dot, rank);
      items_sent++;
   endtask

   // mostly legal ranks, some ranks past the total, some over-length and raw noise
   task automatic send_random_item();
      int unsigned      pick;
      int unsigned      len;
      int unsigned      dash;
      int unsigned      total;
      int unsigned      top;
      logic [LEN_W-1:0] d;
      logic [LEN_W-1:0] o;
      logic [RANK_W-1:0] r;
      pick  = $urandom_range(99, 0);
      len   = $urandom_range(KCU_MAX_LEN, 0);
      dash  = $urandom_range(len, 0);
      total = sb.pascal[len][dash];
      d     = LEN_W'(dash);
      o     = LEN_W'(len - dash);
      if (pick < 15) begin
         // unconstrained noise, often over-length
         d = LEN_W'($urandom_range(KCU_MAX_LEN, 0));
         o = LEN_W'($urandom_range(KCU_MAX_LEN, 0));
         r = RANK_W'($urandom_range(RANK_MAX, 0));
      end else if (pick < 30 && total <= RANK_MAX) begin
         // rank at or past the total count
         if ($urandom_range(1, 0) != 0) r = RANK_W'(total);
         else r = RANK_W'($urandom_range(RANK_MAX, total));
      end else if (pick < 30) begin
         // total exceeds RANK_MAX, so go over-length instead
         d = LEN_W'($urandom_range(KCU_MAX_LEN, 1));
         o = LEN_W'($urandom_range(KCU_MAX_LEN, KCU_MAX_LEN + 1 - d));
         r = RANK_W'($urandom_range(RANK_MAX, 0));
      end else begin
         // legal rank, with the first arrangement and the top drawable rank favored
         top = (total - 1 > RANK_MAX) ? RANK_MAX : total - 1;
         case ($urandom_range(9, 0))
            0: begin
               r = '0;
            end
            1: begin
               r = RANK_W'(top);
            end
            default: begin
               r = RANK_W'($urandom_range(top, 0));
            end
         endcase
      end
      send_item(d, o, r);
   endtask

   initial begin : stimulus
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed corners: empty, single symbol, all dashes, all dots,
      // first and last ranks, one past the total, saturated totals, over-length
      send_item(7'd0,  7'd0,  30'd0);
      send_item(7'd0,  7'd0,  30'd1);
      send_item(7'd1,  7'd0,  30'd0);
      send_item(7'd0,  7'd1,  30'd0);
      send_item(7'd64, 7'd0,  30'd0);
      send_item(7'd64, 7'd0,  30'd1);
      send_item(7'd0,  7'd64, 30'd0);
      send_item(7'd0,  7'd64, 30'd1);
      send_item(7'd1,  7'd63, 30'd0);
      send_item(7'd1,  7'd63, 30'd63);
      send_item(7'd1,  7'd63, 30'd64);
      send_item(7'd63, 7'd1,  30'd63);
      send_item(7'd3,  7'd2,  30'd9);
      send_item(7'd3,  7'd2,  30'd10);
      send_item(7'd10, 7'd10, 30'd184755);
      send_item(7'd10, 7'd10, 30'd184756);
      send_item(7'd32, 7'd32, 30'd0);
      send_item(7'd32, 7'd32, 30'd1000000000);
      send_item(7'd30, 7'd30, 30'd536870912);
      send_item(7'd33, 7'd32, 30'd5);
      send_item(7'd64, 7'd1,  30'd0);
      send_item(7'd64, 7'd64, 30'd1000000000);
      send_item(7'd2,  7'd2,  30'd3);

      // three idle profiles: slow receiver, slow sender, no idling
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct   = 36;
               receiver_idle_pct = 84;
            end
            1: begin
               sender_idle_pct   = 84;
               receiver_idle_pct = 36;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         repeat (ITEMS_PER_PHASE) send_random_item();
      end
      req_valid <= 1'b0;

      // let every pending response drain, then wait out the drain margin
      while (sb.expected_arrangements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d request items under slow-receiver, slow-sender and full-rate phases",
               items_sent);
      $display("responses checked: %0d ok, %0d rank past total, %0d over-length",
               sb.status_seen[STATUS_OK], sb.status_seen[STATUS_RANK],
               sb.status_seen[STATUS_LENGTH]);
      if (sb.mismatches == 0 && sb.expected_arrangements.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
